[sv/indexed_doubly_linked_list_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the indexed doubly linked list
// Concurrent checks on clk, masked while rst is high (IDLL_ASSERT) or not.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define INDEXED_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define IDLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IDLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDLL_ASSERT(lbl, prop, msg)
`define IDLL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[sv/idll_pkg.sv]
// ----------------------------------------------------------------------------
// idll_pkg
// Shared constants, types and op codes of the indexed doubly linked list.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

  localparam int SLOTS     = 256;
  localparam int DATA_BITS = 32;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int LINK_W    = SLOT_W + 1;
  localparam int CNT_W     = SLOT_W + 1;

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [LINK_W-1:0]    link_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DATA_BITS-1:0] data_t;

  localparam link_t NO_LINK = LINK_W'(SLOTS);

  typedef enum logic [3:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_INS_BEFORE = 4'd4,
    OP_INS_AFTER  = 4'd5,
    OP_MOV_BEFORE = 4'd6,
    OP_MOV_AFTER  = 4'd7,
    OP_ERASE      = 4'd8,
    OP_NTH        = 4'd9,
    OP_NEXT       = 4'd10,
    OP_PREV       = 4'd11,
    OP_CLEAR      = 4'd12
  } op_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  ref_slot;
    logic [7:0]  node_slot;
    logic [7:0]  position;
    logic [31:0] value;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    slot_t       slot;
    logic [31:0] data_out;
    cnt_t        count;
  } res_t;

  typedef struct packed {
    slot_t raddr;
    logic  nx_we;
    slot_t nx_wa;
    link_t nx_wd;
    logic  pv_we;
    slot_t pv_wa;
    link_t pv_wd;
    logic  dt_we;
    slot_t dt_wa;
    data_t dt_wd;
    logic  dl_we;
    slot_t dl_wa;
    logic  dl_wd;
  } mem_req_t;

  typedef struct packed {
    link_t nx;
    link_t pv;
    data_t dt;
    logic  dl;
  } mem_rsp_t;

endpackage

`default_nettype wire

[sv/indexed_doubly_linked_list_top.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top
// Doubly linked list of data words kept in on-chip node memories.
// ----------------------------------------------------------------------------
// Usage:
//   One command transfer on the s_ group yields exactly one result transfer
//   on the m_ group, in order. Commands: push/pop at either end, insert or
//   move next to a reference slot, erase, nth, next, prev and clear.
//   Steps: each command reads its entries, evaluates and fetches its result;
//   ops that rewrite links add writes to the link memories, and a pop or
//   erase that leaves the list non-empty adds a top-of-use check. A walking
//   nth adds a read and a check per walk step (up to half the live count);
//   each hole trimmed from the top of use adds another read and check.
//   Throughput: one command at a time; the next is taken the cycle after
//   the previous result has moved into the output register. That register
//   holds the result while m_tready is low, so a stalled receiver blocks
//   only the result after it, never the one already waiting.
//   Reset (rst, synchronous): the list is empty and no slot is in use; the
//   node memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list_top import idll_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[3:0], ref_slot[11:4], node_slot[19:12], position[27:20], value[59:28]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // ok[0], slot[8:1], data_out[40:9], count[49:41]
  output logic [55:0] m_tdata
);

`include "indexed_doubly_linked_list_top_assert.svh"

  item_t    item;
  res_t     res;
  logic     res_ready;
  mem_req_t req;
  mem_rsp_t rsp;
  logic [0:0] dl_rd;

  assign item.op        = s_tdata[3:0];
  assign item.ref_slot  = s_tdata[11:4];
  assign item.node_slot = s_tdata[19:12];
  assign item.position  = s_tdata[27:20];
  assign item.value     = s_tdata[59:28];

  idll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (item),
    .res      (res),
    .res_ready(res_ready),
    .req      (req),
    .rsp      (rsp)
  );

  // node memories: next links, prev links, data words, deleted marks
  idll_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(req.nx_we), .waddr(req.nx_wa), .wdata(req.nx_wd),
    .raddr(req.raddr), .rdata(rsp.nx)
  );

  idll_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(req.pv_we), .waddr(req.pv_wa), .wdata(req.pv_wd),
    .raddr(req.raddr), .rdata(rsp.pv)
  );

  idll_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_data_ram (
    .clk(clk), .we(req.dt_we), .waddr(req.dt_wa), .wdata(req.dt_wd),
    .raddr(req.raddr), .rdata(rsp.dt)
  );

  idll_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_del_ram (
    .clk(clk), .we(req.dl_we), .waddr(req.dl_wa), .wdata(req.dl_wd),
    .raddr(req.raddr), .rdata(dl_rd)
  );

  assign rsp.dl = dl_rd[0];

  // output register: loads when empty or when its transfer completes
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_tdata <= {6'd0, res.count, res.data_out, res.slot, res.ok};
    end
  end

  `IDLL_ASSERT(a_res_loaded, (res.valid && res_ready) |=> m_tvalid, "result not registered")
  `IDLL_ASSERT(a_no_accept_busy, (m_tvalid && !m_tready && res.valid) |=> res.valid,
    "result dropped while output stalled")

endmodule

`default_nettype wire

[sv/idll_ram.sv]
// ----------------------------------------------------------------------------
// idll_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/idll_ctrl.sv]
// ----------------------------------------------------------------------------
// idll_ctrl
// Sequencer: reads node entries, plans link updates, writes them back.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ctrl import idll_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  item_t    in_item,
  output res_t     res,
  input  logic     res_ready,
  output mem_req_t req,
  input  mem_rsp_t rsp
);

`include "indexed_doubly_linked_list_top_assert.svh"

  typedef struct packed {
    logic  en;
    slot_t addr;
    link_t data;
  } wr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_EVAL, S_WR, S_TRIM_RD, S_TRIM_CHK,
    S_WALK_RD, S_WALK_CHK, S_FETCH, S_DONE
  } state_t;

  function automatic wr_t wr(slot_t a, link_t d);
    wr_t w;
    w.en   = 1'b1;
    w.addr = a;
    w.data = d;
    return w;
  endfunction

  function automatic logic lk_ok(link_t l);
    return l < NO_LINK;
  endfunction

  state_t state;
  item_t  it;
  slot_t  head, tail;
  cnt_t   live, top;
  link_t  a_nx, a_pv;
  logic   a_dl;
  wr_t    nw [3];
  wr_t    pw [3];
  logic   dt_en, dl_en, dl_val, trim;
  logic [1:0] wi;
  slot_t  cur;
  logic [7:0] k;
  logic   dir;
  logic   res_ok;
  slot_t  res_slot;

  // evaluation outputs
  logic   e_ok, e_dt, e_dl_e, e_dl_d, e_wr, e_trim, e_walk, e_dir;
  slot_t  e_slot, e_head, e_tail, e_cur;
  cnt_t   e_live, e_top;
  logic [7:0] e_k;
  wr_t    e_nw [3];
  wr_t    e_pw [3];

  slot_t  addr_a;

  always_comb begin
    unique case (op_t'(it.op))
      OP_POP_FRONT: addr_a = head;
      OP_POP_BACK:  addr_a = tail;
      OP_ERASE:     addr_a = it.node_slot;
      default:      addr_a = it.ref_slot;
    endcase
  end

  always_comb begin
    logic  r_live, na_live, nb_live, full, mv;
    slot_t sn, rs, nd, s;
    link_t p, q, m;
    cnt_t  lm1;
    rs      = it.ref_slot;
    nd      = it.node_slot;
    sn      = top[SLOT_W-1:0];
    full    = (top == CNT_W'(SLOTS));
    r_live  = (CNT_W'(rs) < top) && !a_dl;
    na_live = (CNT_W'(nd) < top) && !a_dl;
    nb_live = (CNT_W'(nd) < top) && !rsp.dl;
    lm1     = live - CNT_W'(1);
    p = NO_LINK;
    q = NO_LINK;
    m = NO_LINK;
    s = '0;
    mv = 1'b0;
    e_ok = 1'b0; e_slot = '0; e_head = head; e_tail = tail; e_live = live; e_top = top;
    e_dt = 1'b0; e_dl_e = 1'b0; e_dl_d = 1'b0; e_wr = 1'b0; e_trim = 1'b0;
    e_walk = 1'b0; e_cur = head; e_k = '0; e_dir = 1'b0;
    for (int i = 0; i < 3; i++) begin
      e_nw[i] = '0;
      e_pw[i] = '0;
    end
    unique case (op_t'(it.op))
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (!full) begin
          e_ok = 1'b1; e_slot = sn; e_top = top + CNT_W'(1); e_live = live + CNT_W'(1);
          e_dt = 1'b1; e_dl_e = 1'b1; e_wr = 1'b1;
          if (live == '0) begin
            e_nw[0] = wr(sn, NO_LINK);
            e_pw[0] = wr(sn, NO_LINK);
            e_head = sn;
            e_tail = sn;
          end else if (op_t'(it.op) == OP_PUSH_FRONT) begin
            e_pw[0] = wr(sn, NO_LINK);
            e_nw[0] = wr(sn, LINK_W'(head));
            e_pw[1] = wr(head, LINK_W'(sn));
            e_head = sn;
          end else begin
            e_nw[0] = wr(sn, NO_LINK);
            e_pw[0] = wr(sn, LINK_W'(tail));
            e_nw[1] = wr(tail, LINK_W'(sn));
            e_tail = sn;
          end
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (r_live && !full) begin
          e_ok = 1'b1; e_slot = sn; e_top = top + CNT_W'(1); e_live = live + CNT_W'(1);
          e_dt = 1'b1; e_dl_e = 1'b1; e_wr = 1'b1;
          if (op_t'(it.op) == OP_INS_BEFORE) begin
            p = a_pv;
            e_pw[0] = wr(sn, p);
            e_nw[0] = wr(sn, LINK_W'(rs));
            e_pw[1] = wr(rs, LINK_W'(sn));
            if (lk_ok(p)) e_nw[1] = wr(p[SLOT_W-1:0], LINK_W'(sn));
            else e_head = sn;
          end else begin
            q = a_nx;
            e_nw[0] = wr(sn, q);
            e_pw[0] = wr(sn, LINK_W'(rs));
            e_nw[1] = wr(rs, LINK_W'(sn));
            if (lk_ok(q)) e_pw[1] = wr(q[SLOT_W-1:0], LINK_W'(sn));
            else e_tail = sn;
          end
        end
      end
      OP_MOV_BEFORE, OP_MOV_AFTER: begin
        if (r_live && nb_live) begin
          e_ok = 1'b1; e_slot = nd;
          mv = (rs != nd) &&
               ((op_t'(it.op) == OP_MOV_BEFORE && rsp.nx != LINK_W'(rs)) ||
                (op_t'(it.op) == OP_MOV_AFTER && rsp.pv != LINK_W'(rs)));
          if (mv) begin
            e_wr = 1'b1;
            p = rsp.pv;
            q = rsp.nx;
            // unlink the node
            if (lk_ok(p)) e_nw[0] = wr(p[SLOT_W-1:0], q);
            else e_head = q[SLOT_W-1:0];
            if (lk_ok(q)) e_pw[0] = wr(q[SLOT_W-1:0], p);
            else e_tail = p[SLOT_W-1:0];
            // relink next to the reference
            if (op_t'(it.op) == OP_MOV_BEFORE) begin
              m = a_pv;
              e_pw[1] = wr(nd, m);
              e_nw[1] = wr(nd, LINK_W'(rs));
              e_pw[2] = wr(rs, LINK_W'(nd));
              if (lk_ok(m)) e_nw[2] = wr(m[SLOT_W-1:0], LINK_W'(nd));
              else e_head = nd;
            end else begin
              m = a_nx;
              e_nw[1] = wr(nd, m);
              e_pw[1] = wr(nd, LINK_W'(rs));
              e_nw[2] = wr(rs, LINK_W'(nd));
              if (lk_ok(m)) e_pw[2] = wr(m[SLOT_W-1:0], LINK_W'(nd));
              else e_tail = nd;
            end
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
        if ((op_t'(it.op) == OP_ERASE) ? na_live : (live != '0)) begin
          s = addr_a;
          e_ok = 1'b1; e_slot = s;
          if (live == CNT_W'(1)) begin
            e_head = '0; e_tail = '0; e_live = '0; e_top = '0;
          end else begin
            e_live = lm1;
            p = a_pv;
            q = a_nx;
            e_wr = 1'b1; e_trim = 1'b1; e_dl_e = 1'b1; e_dl_d = 1'b1;
            if (lk_ok(p)) e_nw[0] = wr(p[SLOT_W-1:0], q);
            else e_head = q[SLOT_W-1:0];
            if (lk_ok(q)) e_pw[0] = wr(q[SLOT_W-1:0], p);
            else e_tail = p[SLOT_W-1:0];
          end
        end
      end
      OP_NTH: begin
        if (live != '0) begin
          e_ok = 1'b1;
          if (CNT_W'(it.position) >= lm1) begin
            e_slot = tail;
          end else if (CNT_W'(it.position) < (live >> 1)) begin
            e_walk = 1'b1; e_cur = head; e_k = it.position; e_dir = 1'b1;
          end else begin
            e_walk = 1'b1; e_cur = tail; e_dir = 1'b0;
            e_k = 8'(lm1 - CNT_W'(it.position));
          end
        end
      end
      OP_NEXT, OP_PREV: begin
        if (r_live) begin
          m = (op_t'(it.op) == OP_NEXT) ? a_nx : a_pv;
          if (lk_ok(m)) begin
            e_ok = 1'b1;
            e_slot = m[SLOT_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        e_ok = 1'b1; e_head = '0; e_tail = '0; e_live = '0; e_top = '0;
      end
      default: begin
      end
    endcase
  end

  // memory requests
  always_comb begin
    req = '0;
    req.raddr = res_slot;
    unique case (state)
      S_RA:      req.raddr = addr_a;
      S_RB:      req.raddr = it.node_slot;
      S_TRIM_RD: req.raddr = SLOT_W'(top - CNT_W'(1));
      S_WALK_RD: req.raddr = cur;
      default:   req.raddr = res_slot;
    endcase
    if (state == S_WR) begin
      req.nx_we = nw[wi].en;
      req.nx_wa = nw[wi].addr;
      req.nx_wd = nw[wi].data;
      req.pv_we = pw[wi].en;
      req.pv_wa = pw[wi].addr;
      req.pv_wd = pw[wi].data;
      req.dt_we = dt_en && (wi == 2'd0);
      req.dl_we = dl_en && (wi == 2'd0);
    end
    req.dt_wa = res_slot;
    req.dt_wd = it.value[DATA_BITS-1:0];
    req.dl_wa = res_slot;
    req.dl_wd = dl_val;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    res.valid    = (state == S_DONE);
    res.ok       = res_ok;
    res.slot     = res_slot;
    res.count    = live;
    res.data_out = (res_ok && op_t'(it.op) != OP_CLEAR) ? 32'(rsp.dt) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      live  <= '0;
      top   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            it    <= in_item;
            state <= S_RA;
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          a_nx  <= rsp.nx;
          a_pv  <= rsp.pv;
          a_dl  <= rsp.dl;
          state <= S_EVAL;
        end
        S_EVAL: begin
          res_ok   <= e_ok;
          res_slot <= e_ok ? e_slot : '0;
          head     <= e_head;
          tail     <= e_tail;
          live     <= e_live;
          top      <= e_top;
          nw       <= e_nw;
          pw       <= e_pw;
          dt_en    <= e_dt;
          dl_en    <= e_dl_e;
          dl_val   <= e_dl_d;
          trim     <= e_trim;
          cur      <= e_cur;
          k        <= e_k;
          dir      <= e_dir;
          wi       <= 2'd0;
          state    <= e_wr ? S_WR : (e_walk ? S_WALK_RD : S_FETCH);
        end
        S_WR: begin
          wi <= wi + 2'd1;
          if (wi == 2'd2) state <= trim ? S_TRIM_RD : S_FETCH;
        end
        S_TRIM_RD: state <= (top == '0) ? S_FETCH : S_TRIM_CHK;
        S_TRIM_CHK: begin
          if (rsp.dl) begin
            top   <= top - CNT_W'(1);
            state <= S_TRIM_RD;
          end else begin
            state <= S_FETCH;
          end
        end
        S_WALK_RD: begin
          if (k == '0) begin
            res_slot <= cur;
            state    <= S_FETCH;
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          cur   <= dir ? rsp.nx[SLOT_W-1:0] : rsp.pv[SLOT_W-1:0];
          k     <= k - 8'd1;
          state <= S_WALK_RD;
        end
        S_FETCH: state <= S_DONE;
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `IDLL_ASSERT(a_live_le_top, (live <= top), "live count exceeds slots in use")
  `IDLL_ASSERT(a_empty_resets, (live == '0) |-> (top == '0), "empty list kept holes")
  `IDLL_ASSERT(a_top_bound, (top <= CNT_W'(SLOTS)), "top of use past memory size")

endmodule

`default_nettype wire

[dv/indexed_doubly_linked_list_top_test.sv]
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top_test
// Self-checking bench: a directed pass over every command and corner of the
// list, then phases of random commands that grow, churn and drain the list.
// A shadow list predicts each result, and results are checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list_top_test;
  import idll_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM   = 900;
  localparam int IDLE_LIMIT   = 5000;  // worst trim walk plus the long hold-off
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 300;   // result index that starts the long hold-off
  localparam int NONE         = SLOTS; // empty link in the shadow list

  // one expected response of the list
  typedef struct {
    bit          ok;
    bit [7:0]    slot;
    bit [31:0]   data_out;
    bit [8:0]    count;
  } list_resp_t;

  // a command waiting for the driver, with the response it must produce
  typedef struct {
    item_t       cmd;
    list_resp_t  resp;
  } cmd_entry_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  cmd_entry_t  pending_cmds[$];
  list_resp_t  expected_resps[$];
  int          error_count = 0;
  int          resp_count = 0;
  int          idle_cycles = 0;

  always #2 clk = ~clk;

  indexed_doubly_linked_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Shadow list. Commands are predicted when queued; the list answers in
  // order, so queue order equals transfer order.
  // --------------------------------------------------------------------------
  bit [31:0] sh_data[SLOTS];
  int        sh_next[SLOTS];
  int        sh_prev[SLOTS];
  bit        sh_dead[SLOTS];
  int        sh_head = 0;
  int        sh_tail = 0;
  int        sh_count = 0;
  int        sh_top = 0;

  function automatic bit sh_live(int s);
    return s < sh_top && !sh_dead[s];
  endfunction

  function automatic void sh_empty();
    sh_head = 0;
    sh_tail = 0;
    sh_count = 0;
    sh_top = 0;
  endfunction

  function automatic void sh_unlink(int s);
    int p, n;
    p = sh_prev[s];
    n = sh_next[s];
    if (p < NONE) sh_next[p] = n; else sh_head = n;
    if (n < NONE) sh_prev[n] = p; else sh_tail = p;
  endfunction

  function automatic void sh_link_before(int s, int r);
    int p;
    p = sh_prev[r];
    sh_prev[s] = p;
    sh_next[s] = r;
    sh_prev[r] = s;
    if (p < NONE) sh_next[p] = s; else sh_head = s;
  endfunction

  function automatic void sh_link_after(int s, int r);
    int n;
    n = sh_next[r];
    sh_next[s] = n;
    sh_prev[s] = r;
    sh_next[r] = s;
    if (n < NONE) sh_prev[n] = s; else sh_tail = s;
  endfunction

  // removal; an emptied list starts over, otherwise holes at the top are trimmed
  function automatic void sh_remove(int s);
    sh_unlink(s);
    sh_count--;
    if (sh_count == 0) begin
      sh_empty();
      return;
    end
    sh_dead[s] = 1'b1;
    while (sh_top > 0 && sh_dead[sh_top-1]) sh_top--;
  endfunction

  function automatic int sh_alloc(bit [31:0] v);
    int s;
    s = sh_top;
    sh_top++;
    sh_data[s] = v;
    sh_dead[s] = 1'b0;
    if (sh_count == 0) begin
      sh_next[s] = NONE;
      sh_prev[s] = NONE;
      sh_head = s;
      sh_tail = s;
    end
    sh_count++;
    return s;
  endfunction

  function automatic list_resp_t list_apply(item_t c);
    list_resp_t rsp;
    bit         ok;
    int         s, h, t, k, m;
    int         r, n, pos;
    bit [31:0]  d;
    bit         was_empty;
    op_t        op;
    ok = 1'b0;
    s = 0;
    d = '0;
    r = c.ref_slot;
    n = c.node_slot;
    pos = c.position;
    was_empty = (sh_count == 0);
    op = op_t'(c.op);
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (sh_top < SLOTS) begin
          h = sh_head;
          t = sh_tail;
          s = sh_alloc(c.value);
          if (!was_empty) begin
            if (op == OP_PUSH_FRONT) sh_link_before(s, h); else sh_link_after(s, t);
          end
          ok = 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (!was_empty) begin
          s = (op == OP_POP_FRONT) ? sh_head : sh_tail;
          d = sh_data[s];
          sh_remove(s);
          ok = 1'b1;
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        if (sh_live(r) && sh_top < SLOTS) begin
          s = sh_alloc(c.value);
          if (op == OP_INS_BEFORE) sh_link_before(s, r); else sh_link_after(s, r);
          ok = 1'b1;
        end
      end
      OP_MOV_BEFORE, OP_MOV_AFTER: begin
        if (sh_live(r) && sh_live(n)) begin
          s = n;
          // moving onto itself or to where it already sits changes nothing
          if (r != n) begin
            if (op == OP_MOV_BEFORE && sh_next[n] != r) begin
              sh_unlink(n);
              sh_link_before(n, r);
            end else if (op == OP_MOV_AFTER && sh_prev[n] != r) begin
              sh_unlink(n);
              sh_link_after(n, r);
            end
          end
          ok = 1'b1;
        end
      end
      OP_ERASE: begin
        if (sh_live(n)) begin
          s = n;
          d = sh_data[n];
          sh_remove(n);
          ok = 1'b1;
        end
      end
      OP_NTH: begin
        if (!was_empty) begin
          if (pos >= sh_count - 1) begin
            s = sh_tail;
          end else if (pos < sh_count / 2) begin
            s = sh_head;
            for (k = 0; k < pos; k++) s = sh_next[s];
          end else begin
            s = sh_tail;
            for (k = 0; k < sh_count - 1 - pos; k++) s = sh_prev[s];
          end
          ok = 1'b1;
        end
      end
      OP_NEXT, OP_PREV: begin
        if (sh_live(r)) begin
          m = (op == OP_NEXT) ? sh_next[r] : sh_prev[r];
          if (m < NONE) begin
            s = m;
            ok = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        sh_empty();
        ok = 1'b1;
      end
      default: ;
    endcase
    if (ok && !(op inside {OP_POP_FRONT, OP_POP_BACK, OP_ERASE, OP_CLEAR}))
      d = sh_data[s];
    if (!ok) begin
      s = 0;
      d = '0;
    end
    rsp.ok = ok;
    rsp.slot = s[7:0];
    rsp.data_out = d;
    rsp.count = sh_count[8:0];
    return rsp;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_cmd(op_t op, int r, int n, int pos, bit [31:0] v);
    cmd_entry_t e;
    e.cmd.op = op;
    e.cmd.ref_slot = r[7:0];
    e.cmd.node_slot = n[7:0];
    e.cmd.position = pos[7:0];
    e.cmd.value = v;
    e.resp = list_apply(e.cmd);
    pending_cmds.push_back(e);
  endfunction

  // mostly a live slot, now and then any slot (holes, above top, out of use)
  function automatic int pick_slot();
    int s;
    if (sh_top > 0 && $urandom_range(0, 9) != 0) begin
      repeat (8) begin
        s = $urandom_range(0, sh_top - 1);
        if (!sh_dead[s]) return s;
      end
    end
    return $urandom_range(0, 255);
  endfunction

  // bias: 0 balanced, 1 mostly adds, 2 mostly removals
  function automatic op_t pick_op(int bias);
    int w;
    w = $urandom_range(0, 99);
    if (w < 2) return op_t'($urandom_range(13, 15));  // unused codes
    if (w < 3) return OP_CLEAR;
    if (bias == 1 && w < 70) return op_t'($urandom_range(0, 1) ? 
                                          $urandom_range(0, 1) : $urandom_range(4, 5));
    if (bias == 2 && w < 60) return ($urandom_range(0, 2) == 0) ? OP_ERASE :
                                     op_t'($urandom_range(2, 3));
    return op_t'($urandom_range(0, 11));
  endfunction

  function automatic void queue_random(op_t op);
    queue_cmd(op, pick_slot(), pick_slot(),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, sh_count),
              $urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Driver: bursts of transfers with random gaps, inputs change on falling edge
  // --------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      s_tvalid <= 1'b1;
      s_tdata  <= {4'b0, pending_cmds[0].cmd.value, pending_cmds[0].cmd.position,
                   pending_cmds[0].cmd.node_slot, pending_cmds[0].cmd.ref_slot,
                   pending_cmds[0].cmd.op};
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // command transfer: move its response into the in-order store
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_resps.push_back(pending_cmds[0].resp);
      void'(pending_cmds.pop_front());
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        // some bursts run back to back with no gap at all
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern redrawn at random from four modes; one long hold-off
  // --------------------------------------------------------------------------
  int  rx_cycle = 0;
  int  rx_mode = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ((rx_cycle / 5) % 2 == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      resp_count++;
      if (resp_count == HOLD_AT) hold_req = 1'b1;
      if (expected_resps.size() == 0) begin
        $error("result transfer with no command outstanding: %h", m_tdata);
        error_count++;
      end else begin
        want = expected_resps.pop_front();
        if (m_tdata[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[8:1] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, m_tdata[8:1]);
          error_count++;
        end
        if (m_tdata[40:9] !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, m_tdata[40:9]);
          error_count++;
        end
        if (m_tdata[49:41] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, m_tdata[49:41]);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("indexed_doubly_linked_list_top_test: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int issued;
    int bias;
    int phase_left;
    op_t op;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: empty-list failures, ends, inserts, moves, walks, invalid slots
    queue_cmd(OP_POP_FRONT, 0, 0, 0, 32'h0);
    queue_cmd(OP_NTH, 0, 0, 0, 32'h0);
    queue_cmd(OP_NEXT, 0, 0, 0, 32'h0);
    queue_cmd(OP_PUSH_FRONT, 0, 0, 0, 32'hFFFF_FFFF);   // slot 0
    queue_cmd(OP_PUSH_BACK, 0, 0, 0, 32'h0000_0000);    // slot 1
    queue_cmd(OP_INS_BEFORE, 1, 0, 0, 32'hA5A5_5A5A);   // slot 2
    queue_cmd(OP_INS_AFTER, 0, 0, 0, 32'h1234_5678);    // slot 3
    queue_cmd(OP_PREV, 0, 0, 0, 32'h0);                 // head has no prev
    queue_cmd(OP_NEXT, 1, 0, 0, 32'h0);                 // tail has no next
    queue_cmd(OP_NEXT, 0, 0, 0, 32'h0);
    queue_cmd(OP_MOV_BEFORE, 2, 2, 0, 32'h0);           // onto itself
    queue_cmd(OP_MOV_AFTER, 0, 3, 0, 32'h0);            // already there
    queue_cmd(OP_MOV_BEFORE, 0, 1, 0, 32'h0);
    queue_cmd(OP_MOV_AFTER, 2, 0, 0, 32'h0);
    queue_cmd(OP_NTH, 0, 0, 255, 32'h0);                // past the end
    queue_cmd(OP_NTH, 0, 0, 1, 32'h0);
    queue_cmd(OP_NTH, 0, 0, 2, 32'h0);
    queue_cmd(OP_INS_AFTER, 255, 0, 0, 32'h0);          // slot out of use
    queue_cmd(OP_ERASE, 0, 3, 0, 32'h0);                // top hole trimmed
    queue_cmd(OP_ERASE, 0, 3, 0, 32'h0);                // already gone
    queue_cmd(op_t'(4'd13), 0, 0, 0, 32'h0);
    queue_cmd(op_t'(4'd15), 255, 255, 255, 32'hFFFF_FFFF);
    queue_cmd(OP_POP_FRONT, 0, 0, 0, 32'h0);
    queue_cmd(OP_POP_BACK, 0, 0, 0, 32'h0);
    queue_cmd(OP_CLEAR, 0, 0, 0, 32'h0);

    // sender pause: let every expected result arrive before the random part
    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);

    // fill memory to the limit, then a few adds that must fail
    while (sh_top < SLOTS) queue_random(op_t'($urandom_range(0, 1)));
    repeat (4) queue_random(op_t'($urandom_range(0, 1) ? 1 : 4));
    issued = SLOTS + 4;
    bias = 2;
    phase_left = 120;
    while (issued < NUM_RANDOM) begin
      if (phase_left == 0) begin
        bias = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 150);
      end
      phase_left--;
      op = pick_op(bias);
      queue_random(op);
      issued++;
      // keep the queue short so the generator tracks the driver loosely
      while (pending_cmds.size() > 32) @(negedge clk);
    end

    wait (pending_cmds.size() == 0 && expected_resps.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("indexed_doubly_linked_list_top_test: done, clean");
    end else begin
      $display("indexed_doubly_linked_list_top_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
